[rtl/hau_pkg.sv]
package hau_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 32;
  localparam int LABEL_W          = 40;
  localparam int TOTAL_W          = 40;
  localparam int IN_IDX_W         = 4;
  localparam int VC_W             = 5;

  // Work done on the record at the head of the column chain as it passes.
  typedef enum logic [2:0] {
    COP_NONE,
    COP_INIT,
    COP_GROW,
    COP_SCAN_TIGHT,
    COP_SCAN_SLACK
  } col_op_e;

  // Operation applied to every column cell in a cycle.
  typedef enum logic [2:0] {
    BOP_HOLD,
    BOP_SHIFT,
    BOP_CLR_SOLVE,
    BOP_CLR_TREE,
    BOP_DELTA,
    BOP_MATCH
  } bcast_op_e;

endpackage

[rtl/hau_cell.sv]
module hau_cell
  import hau_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int CELL_IDX     = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bcast_op_e                        op_i,
  input  logic signed [LABEL_W-1:0]        delta_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]  tag_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]  row_i,
  input  logic [3*$clog2(MAX_VERTICES)+2*LABEL_W+1:0] nxt_i,
  output logic [3*$clog2(MAX_VERTICES)+2*LABEL_W+1:0] rec_o
);

  localparam int IW = $clog2(MAX_VERTICES);

  typedef struct packed {
    logic [IW-1:0]              tag;
    logic signed [LABEL_W-1:0]  label;
    logic signed [LABEL_W-1:0]  slack;
    logic [IW-1:0]              srow;
    logic                       mvld;
    logic [IW-1:0]              midx;
    logic                       tin;
  } col_rec_t;

  col_rec_t rec_q, rec_d;

  always_comb begin
    rec_d = rec_q;
    case (op_i)
      BOP_SHIFT: rec_d = col_rec_t'(nxt_i);
      BOP_CLR_SOLVE: begin
        rec_d.label = '0;
        rec_d.mvld  = 1'b0;
        rec_d.tin   = 1'b0;
      end
      BOP_CLR_TREE: rec_d.tin = 1'b0;
      BOP_DELTA: begin
        if (rec_q.tin) begin
          rec_d.label = rec_q.label + delta_i;
        end else begin
          rec_d.slack = rec_q.slack - delta_i;
        end
      end
      BOP_MATCH: begin
        if (rec_q.tag == tag_i) begin
          rec_d.mvld = 1'b1;
          rec_d.midx = row_i;
        end
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q.tag   <= IW'(CELL_IDX);
      rec_q.label <= '0;
      rec_q.slack <= '0;
      rec_q.srow  <= '0;
      rec_q.mvld  <= 1'b0;
      rec_q.midx  <= '0;
      rec_q.tin   <= 1'b0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

[rtl/hau_col_unit.sv]
module hau_col_unit
  import hau_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  col_op_e                            op_i,
  input  logic [3*$clog2(MAX_VERTICES)+2*LABEL_W+1:0] rec_i,
  input  logic signed [LABEL_W-1:0]          wt_i,
  input  logic signed [LABEL_W-1:0]          rlabel_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]    row_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]  n_i,
  output logic [3*$clog2(MAX_VERTICES)+2*LABEL_W+1:0] rec_o,
  output logic                               hit_o
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic [IW-1:0]              tag;
    logic signed [LABEL_W-1:0]  label;
    logic signed [LABEL_W-1:0]  slack;
    logic [IW-1:0]              srow;
    logic                       mvld;
    logic [IW-1:0]              midx;
    logic                       tin;
  } col_rec_t;

  col_rec_t                  rin, rout;
  logic                      active;
  logic signed [LABEL_W-1:0] sum, slk;

  assign rin    = col_rec_t'(rec_i);
  assign active = CW'(rin.tag) < n_i;
  assign sum    = rlabel_i + rin.label;
  assign slk    = sum - wt_i;

  always_comb begin
    rout  = rin;
    hit_o = 1'b0;
    case (op_i)
      COP_INIT: begin
        if (active) begin
          rout.slack = slk;
          rout.srow  = row_i;
        end
      end
      COP_GROW: begin
        if (active && (slk < rin.slack)) begin
          rout.slack = slk;
          rout.srow  = row_i;
        end
      end
      COP_SCAN_TIGHT: begin
        if (active && !rin.tin && (wt_i == sum)) begin
          hit_o = 1'b1;
          if (rin.mvld) rout.tin = 1'b1;
        end
      end
      COP_SCAN_SLACK: begin
        if (active && !rin.tin && (rin.slack == '0)) begin
          hit_o = 1'b1;
          if (rin.mvld) rout.tin = 1'b1;
        end
      end
      default: rout = rin;
    endcase
  end

  assign rec_o = rout;

endmodule

[rtl/hungarian_assignment_unit.sv]
// Channel  | Direction | Handshake                | Payload
// input    | in        | in_valid_i / in_stall_o  | row_i, col_i, weight_i, last_i
// output   | out       | out_valid_o / out_stall_i| row_res_o, assigned_col_o,
//          |           |                          | total_weight_o, last_res_o
// config   | in        | cfg_valid_i / cfg_ready_o| cfg_data_i (vertex count)
//
// Loading takes one matrix entry per cycle. The entry marked last starts the
// solve, during which the input stalls. Every pass over the columns starts with
// a read setup state, then handles one column per cycle as the column records
// rotate through the chain past the head unit, unless a growth pass suspends
// it, and ends in a state that chooses what follows. A solve costs n row-max
// passes plus, per augmentation, one init pass and one pass per queued row, per
// tree growth, per slack minimum and per slack rescan, all served by the single
// weight memory read port feeding the head unit.
// Results then follow one row at a time while the output is not stalled.
// Reset is asynchronous and active low; it clears the labels and matching but
// not the weight memory, which must be written before it is solved.
module hungarian_assignment_unit
  import hau_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [IN_IDX_W-1:0]           row_i,
  input  logic [IN_IDX_W-1:0]           col_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [IN_IDX_W-1:0]           row_res_o,
  output logic [IN_IDX_W-1:0]           assigned_col_o,
  output logic signed [TOTAL_W-1:0]     total_weight_o,
  output logic                          last_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [VC_W-1:0]               cfg_data_i
);

  localparam int IW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = 3 * IW + 2 * LABEL_W + 2;

  typedef struct packed {
    logic [IW-1:0]              tag;
    logic signed [LABEL_W-1:0]  label;
    logic signed [LABEL_W-1:0]  slack;
    logic [IW-1:0]              srow;
    logic                       mvld;
    logic [IW-1:0]              midx;
    logic                       tin;
  } col_rec_t;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_SETUP    = 4'd2;
  localparam logic [3:0] S_PASS     = 4'd3;
  localparam logic [3:0] S_NEXT     = 4'd4;
  localparam logic [3:0] S_BFS      = 4'd5;
  localparam logic [3:0] S_DELTA    = 4'd6;
  localparam logic [3:0] S_AUG      = 4'd7;
  localparam logic [3:0] S_ROOT     = 4'd8;
  localparam logic [3:0] S_OUT_INIT = 4'd9;
  localparam logic [3:0] S_OUT_RD   = 4'd10;
  localparam logic [3:0] S_OUT_WR   = 4'd11;

  // Kinds of column pass.
  localparam logic [2:0] PK_RMAX  = 3'd0;
  localparam logic [2:0] PK_INIT  = 3'd1;
  localparam logic [2:0] PK_GROW  = 3'd2;
  localparam logic [2:0] PK_SCAN1 = 3'd3;
  localparam logic [2:0] PK_SCAN2 = 3'd4;
  localparam logic [2:0] PK_MIN   = 3'd5;

  logic [3:0]      state_q;
  logic [VC_W-1:0] vc_q;
  logic [CW-1:0]   n_eff;

  // Weight memory with a registered read port.
  logic signed [WEIGHT_BITS-1:0] mem [DEPTH];
  logic signed [WEIGHT_BITS-1:0] rd_data_q;
  logic [AW-1:0]                 wr_addr, rd_addr;
  logic                          wr_en;
  logic [IW-1:0]                 rd_row, rd_col;
  logic signed [LABEL_W-1:0]     wt40;

  // Row side state.
  logic signed [LABEL_W-1:0] row_label_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   rmatch_vld_q;
  logic [IW-1:0]             rmatch_q    [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   rin_tree_q;
  logic [MAX_VERTICES-1:0]   par_vld_q;
  logic [IW-1:0]             par_q       [MAX_VERTICES];
  logic [IW-1:0]             queue_q     [MAX_VERTICES];
  logic [CW-1:0]             wr_q, rd_q;

  // Search control.
  logic                      found_q, stop_q, have_q;
  logic [IW-1:0]             fr_q, fc_q;
  logic                      fr_vld_q, fc_vld_q;
  logic signed [LABEL_W-1:0] delta_q;
  logic [CW:0]               steps_q;
  logic [2:0]                pk_q, sv_pk_q;
  logic [IW-1:0]             pass_row_q, sv_row_q;
  logic [CW-1:0]             cnt_q, sv_cnt_q;
  logic                      susp_q;
  logic [CW-1:0]             x_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic                      pass_grow;

  // Output register.
  logic                      out_vld_q;
  logic [IN_IDX_W-1:0]       out_row_q, out_col_q;
  logic signed [TOTAL_W-1:0] out_tot_q;
  logic                      out_last_q;

  // Column chain.
  logic [RW-1:0]  cell_rec [MAX_VERTICES];
  logic [RW-1:0]  unit_rec;
  col_rec_t       head, head_nxt;
  logic           unit_hit;
  col_op_e        cop;
  bcast_op_e      bop;
  logic           head_act;
  logic [MAX_VERTICES-1:0] col_mvld;

  // Root search.
  logic          root_ok;
  logic [IW-1:0] root_idx;
  logic          aug_go;
  logic          out_load;

  assign head     = col_rec_t'(cell_rec[0]);
  assign head_nxt = col_rec_t'(cell_rec[1]);
  assign head_act = CW'(head.tag) < n_eff;
  assign wt40     = LABEL_W'(rd_data_q);

  // Zero acts as one, anything above the chain length as the chain length.
  always_comb begin
    if (vc_q == '0) begin
      n_eff = CW'(1);
    end else if (int'(vc_q) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = CW'(vc_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_W'(16);
    end else if (cfg_valid_i && cfg_ready_o) begin
      vc_q <= cfg_data_i;
    end
  end

  // Entries outside the chain length are dropped but may still start a solve.
  assign wr_en   = in_valid_i && !in_stall_o &&
                   (int'(row_i) < MAX_VERTICES) && (int'(col_i) < MAX_VERTICES);
  assign wr_addr = AW'(IW'(row_i)) * AW'(MAX_VERTICES) + AW'(IW'(col_i));

  // The read address is prefetched one column ahead of the head unit.
  always_comb begin
    case (state_q)
      S_PASS: begin
        rd_row = pass_row_q;
        rd_col = head_nxt.tag;
      end
      S_OUT_RD, S_OUT_WR: begin
        rd_row = x_q[IW-1:0];
        rd_col = rmatch_q[x_q[IW-1:0]];
      end
      default: begin
        rd_row = pass_row_q;
        rd_col = head.tag;
      end
    endcase
  end
  assign rd_addr = AW'(rd_row) * AW'(MAX_VERTICES) + AW'(rd_col);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= weight_i;
    rd_data_q <= mem[rd_addr];
  end

  // Work for the head unit in this cycle.
  always_comb begin
    cop = COP_NONE;
    if ((state_q == S_PASS) && !stop_q) begin
      case (pk_q)
        PK_INIT:  cop = COP_INIT;
        PK_GROW:  cop = COP_GROW;
        PK_SCAN1: cop = COP_SCAN_TIGHT;
        PK_SCAN2: cop = COP_SCAN_SLACK;
        default:  cop = COP_NONE;
      endcase
    end
  end

  assign aug_go = ({1'b0, steps_q} <= {2'b00, n_eff}) && fr_vld_q && fc_vld_q;

  // A scan hit on a matched column whose row must join the tree suspends the
  // scan for a growth pass.
  assign pass_grow = unit_hit && head.mvld &&
                     ((pk_q == PK_SCAN1) || !rin_tree_q[head.midx]);

  always_comb begin
    case (state_q)
      S_PASS:  bop = BOP_SHIFT;
      S_START: bop = BOP_CLR_SOLVE;
      S_ROOT:  bop = BOP_CLR_TREE;
      S_DELTA: bop = BOP_DELTA;
      S_AUG:   bop = aug_go ? BOP_MATCH : BOP_HOLD;
      default: bop = BOP_HOLD;
    endcase
  end

  hau_col_unit #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_col_unit (
    .op_i    (cop),
    .rec_i   (cell_rec[0]),
    .wt_i    (wt40),
    .rlabel_i(row_label_q[pass_row_q]),
    .row_i   (pass_row_q),
    .n_i     (n_eff),
    .rec_o   (unit_rec),
    .hit_o   (unit_hit)
  );

  // The records rotate toward the head; the head's updated record re-enters
  // at the tail, so a full pass brings every column back to its home cell.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_chain
    logic [RW-1:0] nxt;
    col_rec_t      rec_view;
    if (k == MAX_VERTICES - 1) begin : g_tail
      assign nxt = unit_rec;
    end else begin : g_mid
      assign nxt = cell_rec[k+1];
    end
    hau_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .CELL_IDX    (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (bop),
      .delta_i(delta_q),
      .tag_i  (fc_q),
      .row_i  (fr_q),
      .nxt_i  (nxt),
      .rec_o  (cell_rec[k])
    );
    assign rec_view    = col_rec_t'(cell_rec[k]);
    assign col_mvld[k] = rec_view.mvld;
  end

  // First unmatched row among those in use.
  always_comb begin
    root_ok  = 1'b0;
    root_idx = '0;
    for (int r = 0; r < MAX_VERTICES; r++) begin
      if (!root_ok && (r < int'(n_eff)) && !rmatch_vld_q[r]) begin
        root_ok  = 1'b1;
        root_idx = IW'(r);
      end
    end
  end

  assign out_load = (state_q == S_OUT_WR) && (!out_vld_q || !out_stall_i);

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rmatch_vld_q <= '0;
      rin_tree_q   <= '0;
      par_vld_q    <= '0;
      wr_q         <= '0;
      rd_q         <= '0;
      found_q      <= 1'b0;
      stop_q       <= 1'b0;
      have_q       <= 1'b0;
      fr_vld_q     <= 1'b0;
      fc_vld_q     <= 1'b0;
      susp_q       <= 1'b0;
      steps_q      <= '0;
      pk_q         <= PK_RMAX;
      sv_pk_q      <= PK_RMAX;
      cnt_q        <= '0;
      sv_cnt_q     <= '0;
      x_q          <= '0;
      pass_row_q   <= '0;
      sv_row_q     <= '0;
      fr_q         <= '0;
      fc_q         <= '0;
      delta_q      <= '0;
      total_q      <= '0;
      for (int r = 0; r < MAX_VERTICES; r++) begin
        row_label_q[r] <= '0;
        rmatch_q[r]    <= '0;
        par_q[r]       <= '0;
        queue_q[r]     <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && last_i) state_q <= S_START;
        end

        S_START: begin
          for (int r = 0; r < MAX_VERTICES; r++) row_label_q[r] <= '0;
          rmatch_vld_q <= '0;
          found_q      <= 1'b0;
          stop_q       <= 1'b0;
          susp_q       <= 1'b0;
          x_q          <= '0;
          pk_q         <= PK_RMAX;
          pass_row_q   <= '0;
          cnt_q        <= CW'(MAX_VERTICES);
          state_q      <= S_SETUP;
        end

        S_SETUP: state_q <= S_PASS;

        S_PASS: begin
          if (!pass_grow) begin
            cnt_q <= cnt_q - 1'b1;
            if (cnt_q == CW'(1)) state_q <= S_NEXT;
          end
          if (!stop_q) begin
            case (pk_q)
              PK_RMAX: begin
                if (head_act && (wt40 > row_label_q[pass_row_q])) begin
                  row_label_q[pass_row_q] <= wt40;
                end
              end
              PK_MIN: begin
                if (head_act && !head.tin && (!have_q || (head.slack < delta_q))) begin
                  delta_q <= head.slack;
                  have_q  <= 1'b1;
                end
              end
              PK_SCAN1, PK_SCAN2: begin
                if (unit_hit) begin
                  if (!head.mvld) begin
                    // Free column: the augmenting path ends here.
                    found_q  <= 1'b1;
                    stop_q   <= 1'b1;
                    fr_q     <= (pk_q == PK_SCAN1) ? pass_row_q : head.srow;
                    fc_q     <= head.tag;
                    fr_vld_q <= 1'b1;
                    fc_vld_q <= 1'b1;
                  end else if (pass_grow) begin
                    // Matched row joins the tree; grow it before going on.
                    if (wr_q < CW'(MAX_VERTICES)) begin
                      queue_q[wr_q[IW-1:0]] <= head.midx;
                      wr_q <= wr_q + 1'b1;
                    end
                    rin_tree_q[head.midx] <= 1'b1;
                    par_vld_q[head.midx]  <= 1'b1;
                    par_q[head.midx]      <= (pk_q == PK_SCAN1) ? pass_row_q : head.srow;
                    sv_pk_q    <= pk_q;
                    sv_row_q   <= pass_row_q;
                    sv_cnt_q   <= cnt_q - 1'b1;
                    susp_q     <= 1'b1;
                    pk_q       <= PK_GROW;
                    pass_row_q <= head.midx;
                    cnt_q      <= CW'(MAX_VERTICES);
                    state_q    <= S_SETUP;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_NEXT: begin
          stop_q <= 1'b0;
          case (pk_q)
            PK_RMAX: begin
              if ((x_q + 1'b1) < n_eff) begin
                x_q        <= x_q + 1'b1;
                pass_row_q <= x_q[IW-1:0] + 1'b1;
                cnt_q      <= CW'(MAX_VERTICES);
                state_q    <= S_SETUP;
              end else begin
                state_q <= S_ROOT;
              end
            end
            PK_GROW: begin
              susp_q <= 1'b0;
              if (susp_q && (sv_cnt_q != '0)) begin
                pk_q       <= sv_pk_q;
                pass_row_q <= sv_row_q;
                cnt_q      <= sv_cnt_q;
                state_q    <= S_SETUP;
              end else begin
                state_q <= S_BFS;
              end
            end
            PK_MIN: state_q <= have_q ? S_DELTA : S_OUT_INIT;
            default: state_q <= S_BFS;
          endcase
        end

        S_BFS: begin
          if (found_q) begin
            steps_q <= '0;
            state_q <= S_AUG;
          end else if (rd_q < wr_q) begin
            rd_q       <= rd_q + 1'b1;
            pk_q       <= PK_SCAN1;
            pass_row_q <= queue_q[rd_q[IW-1:0]];
            cnt_q      <= CW'(MAX_VERTICES);
            state_q    <= S_SETUP;
          end else begin
            have_q  <= 1'b0;
            pk_q    <= PK_MIN;
            cnt_q   <= CW'(MAX_VERTICES);
            state_q <= S_SETUP;
          end
        end

        S_DELTA: begin
          for (int r = 0; r < MAX_VERTICES; r++) begin
            if (rin_tree_q[r]) row_label_q[r] <= row_label_q[r] - delta_q;
          end
          wr_q       <= '0;
          rd_q       <= '0;
          pk_q       <= PK_SCAN2;
          pass_row_q <= '0;
          cnt_q      <= CW'(MAX_VERTICES);
          state_q    <= S_SETUP;
        end

        S_AUG: begin
          if (aug_go) begin
            rmatch_vld_q[fr_q] <= 1'b1;
            rmatch_q[fr_q]     <= fc_q;
            fr_q     <= par_q[fr_q];
            fr_vld_q <= par_vld_q[fr_q];
            fc_q     <= rmatch_q[fr_q];
            fc_vld_q <= rmatch_vld_q[fr_q];
            steps_q  <= steps_q + 1'b1;
          end else begin
            state_q <= S_ROOT;
          end
        end

        S_ROOT: begin
          found_q <= 1'b0;
          if (root_ok) begin
            rin_tree_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << root_idx;
            par_vld_q  <= '0;
            queue_q[0] <= root_idx;
            wr_q       <= CW'(1);
            rd_q       <= '0;
            pk_q       <= PK_INIT;
            pass_row_q <= root_idx;
            cnt_q      <= CW'(MAX_VERTICES);
            state_q    <= S_SETUP;
          end else begin
            state_q <= S_OUT_INIT;
          end
        end

        S_OUT_INIT: begin
          x_q     <= '0;
          total_q <= '0;
          state_q <= S_OUT_RD;
        end

        S_OUT_RD: state_q <= S_OUT_WR;

        S_OUT_WR: begin
          if (out_load) begin
            if (rmatch_vld_q[x_q[IW-1:0]]) total_q <= total_q + wt40;
            if (x_q == n_eff - 1'b1) begin
              state_q <= S_IDLE;
            end else begin
              x_q     <= x_q + 1'b1;
              state_q <= S_OUT_RD;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Output register; it is loaded only when empty or being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= IN_IDX_W'(x_q);
      out_col_q  <= rmatch_vld_q[x_q[IW-1:0]] ? IN_IDX_W'(rmatch_q[x_q[IW-1:0]]) : '0;
      out_tot_q  <= rmatch_vld_q[x_q[IW-1:0]] ? total_q + wt40 : total_q;
      out_last_q <= (x_q == n_eff - 1'b1);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign row_res_o      = out_row_q;
  assign assigned_col_o = out_col_q;
  assign total_weight_o = out_tot_q;
  assign last_res_o     = out_last_q;

  // A pass never runs with its column count exhausted.
  a_pass_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) |-> (cnt_q != '0))
    else $error("column pass running with zero count");

  // In the search state between passes the chain is back in its home alignment.
  a_chain_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BFS) |-> (head.tag == '0))
    else $error("column chain out of alignment");

  // The matching has as many matched rows as matched columns.
  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT) |-> ($countones(rmatch_vld_q) == $countones(col_mvld)))
    else $error("row and column matching disagree");

  // The search queue never overruns.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q <= CW'(MAX_VERTICES)) && (rd_q <= wr_q))
    else $error("search queue pointers out of range");

endmodule
